// File: src/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg: shared types and constants for the RC4 cipher
// Command and status codes, permutation size, memory request structs.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int SBOX_DEPTH = 256;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    CMD_KEY      = 2'd0,
    CMD_SCHEDULE = 2'd1,
    CMD_DATA     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_KEYED = 2'd3
  } status_e;

  // permutation memory access, one write and one read per cycle
  typedef struct packed {
    logic  we;
    byte_t waddr;
    byte_t wdata;
    byte_t raddr;
  } sbox_req_t;

  // key store append request
  typedef struct packed {
    logic  append;
    byte_t data;
  } key_req_t;

endpackage

// File: src/rc4_if.sv
// ----------------------------------------------------------------------------
// rc4_if: valid/ready channels of the RC4 cipher
// Input channel carries a command and a byte, output channel a byte and status.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] value_in;

  modport source (output valid, output command, output value_in, input ready);
  modport sink   (input valid, input command, input value_in, output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_out;
  logic [1:0] status;

  modport source (output valid, output value_out, output status, input ready);
  modport sink   (input valid, input value_out, input status, output ready);
endinterface

// File: src/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher: RC4 byte cipher with key store and key schedule
// Sequencer around one permutation memory and one shared 8-bit adder.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  in_i    | in  | valid / ready  | command[1:0], value_in[7:0]
//  out_o   | out | valid / ready  | value_out[7:0], status[1:0]
//
//  Key byte, empty schedule, unkeyed data and unused code: result is loaded on
//  the accepting edge; the next item may follow in the next cycle.
//  Keyed data byte: S[i] is read on the accepting edge, S[j] in S_D1 and the
//  keystream byte in S_D2; S_D3 loads the result, and no new item is taken
//  before then; bound by the single read port of the permutation memory.
//  Schedule with a key: identity fill in S_FILL, then S_K1, S_K2, S_K3 for
//  each entry, during which in_i.ready is low; its result is issued at once.
//  Reset clears the key length, both indices and the keyed flag; a full output
//  register that is not taken holds the block off.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int MAX_KEY = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rc4_in_if.sink       in_i,
  rc4_out_if.source    out_o
);

  localparam int LenW = $clog2(MAX_KEY + 1);
  localparam int IdxW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_K1, S_K2, S_K3, S_D1, S_D2, S_D3
  } state_e;

  state_e             state_q;
  rc4_pkg::byte_t     i_q, j_q, n_q;
  rc4_pkg::byte_t     si_q, sj_q, sn_q, din_q;
  logic [IdxW-1:0]    k_q;
  logic [IdxW-1:0]    k_nxt;
  logic [IdxW-1:0]    key_raddr;
  logic               byp_q;
  logic               keyed_q;
  logic               out_valid_q;
  rc4_pkg::byte_t     out_value_q;
  rc4_pkg::status_e   out_status_q;

  rc4_pkg::sbox_req_t sbox_req;
  rc4_pkg::byte_t     sbox_rdata;
  rc4_pkg::key_req_t  key_req;
  rc4_pkg::byte_t     key_rdata;
  logic [LenW-1:0]    key_len;
  logic               key_full;

  rc4_pkg::byte_t     add_a, add_b, add_c, sum;
  rc4_pkg::byte_t     sn_eff, ks;
  logic               out_free, accept;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept     = in_i.valid && in_i.ready;

  assign key_req.append = accept && (in_i.command == rc4_pkg::CMD_KEY);
  assign key_req.data   = in_i.value_in;

  // key index wraps at the current key length
  assign k_nxt = ((LenW'(k_q) + LenW'(1)) >= key_len) ? '0 : k_q + IdxW'(1);

  // write in K3 can hit the entry read for the next step
  assign sn_eff = byp_q ? sn_q : sbox_rdata;

  assign sum = add_a + add_b + add_c;

  always_comb begin
    sbox_req.we    = 1'b0;
    sbox_req.waddr = n_q;
    sbox_req.wdata = sbox_rdata;
    sbox_req.raddr = i_q + 8'd1;
    add_a          = j_q;
    add_b          = sbox_rdata;
    add_c          = 8'd0;
    key_raddr      = k_q;
    ks             = sbox_rdata;
    case (state_q)
      S_FILL: begin
        sbox_req.we    = 1'b1;
        sbox_req.wdata = n_q;
        sbox_req.raddr = 8'd0;
      end
      S_K1: begin
        add_b          = sn_eff;
        add_c          = key_rdata;
        sbox_req.raddr = sum;
      end
      S_K2: begin
        sbox_req.we = 1'b1;
      end
      S_K3: begin
        sbox_req.we    = 1'b1;
        sbox_req.waddr = j_q;
        sbox_req.wdata = sn_q;
        sbox_req.raddr = n_q + 8'd1;
        key_raddr      = k_nxt;
      end
      S_D1: begin
        sbox_req.raddr = sum;
      end
      S_D2: begin
        sbox_req.we    = 1'b1;
        sbox_req.waddr = i_q;
        add_a          = si_q;
        sbox_req.raddr = sum;
      end
      S_D3: begin
        sbox_req.we    = 1'b1;
        sbox_req.waddr = j_q;
        sbox_req.wdata = si_q;
        add_a          = si_q;
        add_b          = sj_q;
        sbox_req.raddr = sum;
        // rdata is the pre-swap entry; patch in the two swapped values
        if (sum == j_q) begin
          ks = si_q;
        end else if (sum == i_q) begin
          ks = sj_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      n_q          <= '0;
      k_q          <= '0;
      byp_q        <= 1'b0;
      keyed_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= rc4_pkg::ST_OK;
      si_q         <= '0;
      sj_q         <= '0;
      sn_q         <= '0;
      din_q        <= '0;
    end else begin
      // an accepted item always drives the output valid itself (a keyed data byte clears it)
      if (out_valid_q && out_o.ready && !accept) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (in_i.command)
              rc4_pkg::CMD_KEY: begin
                out_valid_q  <= 1'b1;
                out_value_q  <= '0;
                out_status_q <= key_full ? rc4_pkg::ST_FULL : rc4_pkg::ST_OK;
              end
              rc4_pkg::CMD_SCHEDULE: begin
                out_valid_q <= 1'b1;
                out_value_q <= '0;
                if (key_len == '0) begin
                  keyed_q      <= 1'b0;
                  out_status_q <= rc4_pkg::ST_EMPTY;
                end else begin
                  out_status_q <= rc4_pkg::ST_OK;
                  state_q      <= S_FILL;
                  n_q          <= '0;
                  j_q          <= '0;
                  k_q          <= '0;
                  byp_q        <= 1'b0;
                end
              end
              rc4_pkg::CMD_DATA: begin
                if (keyed_q) begin
                  out_valid_q <= 1'b0;
                  i_q         <= i_q + 8'd1;
                  din_q       <= in_i.value_in;
                  state_q     <= S_D1;
                end else begin
                  out_valid_q  <= 1'b1;
                  out_value_q  <= in_i.value_in;
                  out_status_q <= rc4_pkg::ST_NOT_KEYED;
                end
              end
              default: begin
                out_valid_q  <= 1'b1;
                out_value_q  <= '0;
                out_status_q <= rc4_pkg::ST_OK;
              end
            endcase
          end
        end
        S_FILL: begin
          n_q <= n_q + 8'd1;
          if (n_q == 8'hFF) begin
            state_q <= S_K1;
          end
        end
        S_K1: begin
          sn_q    <= sn_eff;
          j_q     <= sum;
          state_q <= S_K2;
        end
        S_K2: begin
          state_q <= S_K3;
        end
        S_K3: begin
          n_q   <= n_q + 8'd1;
          k_q   <= k_nxt;
          byp_q <= (j_q == n_q + 8'd1);
          if (n_q == 8'hFF) begin
            i_q     <= '0;
            j_q     <= '0;
            keyed_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_K1;
          end
        end
        S_D1: begin
          si_q    <= sbox_rdata;
          j_q     <= sum;
          state_q <= S_D2;
        end
        S_D2: begin
          sj_q    <= sbox_rdata;
          state_q <= S_D3;
        end
        S_D3: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= din_q ^ ks;
            out_status_q <= rc4_pkg::ST_OK;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value_out = out_value_q;
  assign out_o.status    = out_status_q;

  rc4_sbox u_sbox (
    .clk_i   (clk_i),
    .req_i   (sbox_req),
    .rdata_o (sbox_rdata)
  );

  rc4_key_mem #(
    .MaxKey (MAX_KEY)
  ) u_key_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (key_req),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata),
    .len_o   (key_len),
    .full_o  (key_full)
  );

  // keyed only comes up at the end of the last schedule step
  a_keyed_from_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(keyed_q) |-> $past(state_q) == S_K3)
    else $error("keyed set outside schedule");

  // a keyed data item goes straight into the stream sequence
  a_data_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.command == rc4_pkg::CMD_DATA) && keyed_q |=> state_q == S_D1)
    else $error("keyed data item did not start the stream sequence");

  // the permutation is never written while idle or in a read-only step
  a_sbox_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sbox_req.we |-> (state_q != S_IDLE) && (state_q != S_K1) && (state_q != S_D1))
    else $error("permutation write in a read-only state");

  // the last schedule step returns to idle with both stream indices cleared
  a_sched_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_K3) && (n_q == 8'hFF) |=> (state_q == S_IDLE) && (i_q == '0) && (j_q == '0))
    else $error("schedule end did not clear the stream indices");

endmodule

// File: src/rc4_sbox.sv
// ----------------------------------------------------------------------------
// rc4_sbox: 256 x 8 permutation memory
// One write port and one read port; read data is registered and returns the
// old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
module rc4_sbox (
  input  logic              clk_i,
  input  rc4_pkg::sbox_req_t req_i,
  output rc4_pkg::byte_t    rdata_o
);

  rc4_pkg::byte_t mem_q [rc4_pkg::SBOX_DEPTH];
  rc4_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rc4_key_mem.sv
// ----------------------------------------------------------------------------
// rc4_key_mem: key byte store with fill count
// Appends bytes until MaxKey are held; registered read port for the schedule.
// ----------------------------------------------------------------------------
module rc4_key_mem #(
  parameter int MaxKey = 256,
  localparam int LenW = $clog2(MaxKey + 1),
  localparam int IdxW = (MaxKey > 1) ? $clog2(MaxKey) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rc4_pkg::key_req_t   req_i,
  input  logic [IdxW-1:0]     raddr_i,
  output rc4_pkg::byte_t      rdata_o,
  output logic [LenW-1:0]     len_o,
  output logic                full_o
);

  rc4_pkg::byte_t  mem_q [MaxKey];
  rc4_pkg::byte_t  rdata_q;
  logic [LenW-1:0] len_q;
  logic [LenW-1:0] len_d;
  logic            full;
  logic            wr_en;

  assign full  = (len_q == LenW'(MaxKey));
  assign wr_en = req_i.append && !full;
  assign len_d = wr_en ? len_q + LenW'(1) : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q[IdxW-1:0]] <= req_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign len_o   = len_q;
  assign full_o  = full;

endmodule
